@@ src/timer_irq_controller_assert.svh @@
// Assertion macros shared by the timer and interrupt controller modules.
// Depends on nothing; every user has a clock named clk and reset rst_n.
`ifndef TIMER_IRQ_CONTROLLER_ASSERT_SVH
`define TIMER_IRQ_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tic_pkg.sv @@
// Shared types, register map and helpers for the timer and interrupt controller.
// Used by tic_store, tic_regs and timer_irq_controller; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tic_pkg;

  localparam int REG_WORDS = 64;
  localparam int STORE_AW  = $clog2(REG_WORDS);
  localparam int WORD_W    = 6;
  localparam int DATA_W    = 32;
  localparam int LVL_W     = 4;
  localparam int OP_W      = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
  localparam logic [OP_W-1:0] OP_ACK   = 2'd3;

  // Register map, word indexes from byte offsets
  localparam logic [WORD_W-1:0] W_T1_CNT = WORD_W'(12'h040 / 4);
  localparam logic [WORD_W-1:0] W_T1_RLD = WORD_W'(12'h044 / 4);
  localparam logic [WORD_W-1:0] W_T1_CTL = WORD_W'(12'h048 / 4);
  localparam logic [WORD_W-1:0] W_WDOG   = WORD_W'(12'h04C / 4);
  localparam logic [WORD_W-1:0] W_T2_CNT = WORD_W'(12'h050 / 4);
  localparam logic [WORD_W-1:0] W_T2_RLD = WORD_W'(12'h054 / 4);
  localparam logic [WORD_W-1:0] W_T2_CTL = WORD_W'(12'h058 / 4);
  localparam logic [WORD_W-1:0] W_PS_CNT = WORD_W'(12'h060 / 4);
  localparam logic [WORD_W-1:0] W_PS_RLD = WORD_W'(12'h064 / 4);
  localparam logic [WORD_W-1:0] W_TICK   = WORD_W'(12'h06C / 4);
  localparam logic [WORD_W-1:0] W_MASK   = WORD_W'(12'h090 / 4);
  localparam logic [WORD_W-1:0] W_PEND   = WORD_W'(12'h094 / 4);
  localparam logic [WORD_W-1:0] W_FORCE  = WORD_W'(12'h098 / 4);
  localparam logic [WORD_W-1:0] W_CLEAR  = WORD_W'(12'h09C / 4);

  // Timer control bits and interrupt lines
  localparam int CTL_EN_BIT   = 0;
  localparam int CTL_RLD_BIT  = 1;
  localparam int CTL_LOAD_BIT = 2;
  localparam logic [DATA_W-1:0] IRQ_T1 = 32'h0000_0100;
  localparam logic [DATA_W-1:0] IRQ_T2 = 32'h0000_0200;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] word;
    logic [DATA_W-1:0] wdata;
    logic [LVL_W-1:0]  lvl;
  } item_t;

  typedef struct packed {
    logic              fired;
    logic [LVL_W-1:0]  int_level;
    logic [DATA_W-1:0] read_data;
  } result_t;

  // Highest set bit among levels 1..15, zero if none
  function automatic logic [LVL_W-1:0] irq_prio(input logic [DATA_W-1:0] eff);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int i = 1; i < 16; i++) begin
      if (eff[i]) lvl = LVL_W'(i);
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

@@ src/tic_store.sv @@
// Plain word storage behind the register window, with per-word valid bits.
// Depends on tic_pkg; read data is registered, unwritten words read zero.
`timescale 1ns / 1ps
`default_nettype none

module tic_store (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       acc_en,    // item transfer on the input side
  input  wire logic                       wr_en,
  input  wire logic [tic_pkg::WORD_W-1:0] word,
  input  wire logic [tic_pkg::DATA_W-1:0] wdata,
  output logic      [tic_pkg::DATA_W-1:0] rd_data
);

  logic [tic_pkg::DATA_W-1:0]    mem [tic_pkg::REG_WORDS];
  logic [tic_pkg::REG_WORDS-1:0] vld_r;
  logic [tic_pkg::DATA_W-1:0]    q_r;
  logic                          q_vld_r;
  logic [tic_pkg::STORE_AW-1:0]  idx;
  logic                          in_range;

  assign idx      = tic_pkg::STORE_AW'(word);
  assign in_range = (32'(word) < tic_pkg::REG_WORDS);

  always_ff @(posedge clk) begin
    if (acc_en && wr_en && in_range) begin
      mem[idx] <= wdata;
    end
    if (acc_en) begin
      q_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else if (acc_en) begin
      q_vld_r <= in_range && vld_r[idx];
      if (wr_en && in_range) vld_r[idx] <= 1'b1;
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

`default_nettype wire

@@ src/tic_regs.sv @@
// Named registers: prescaler, tick counter, two timers, watchdog, interrupt logic.
// Depends on tic_pkg; produces the result of the item held in the input stage.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_irq_controller_assert.svh"

module tic_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       fire,      // input stage advances this cycle
  input  wire tic_pkg::item_t             item,
  input  wire logic [tic_pkg::DATA_W-1:0] store_data,
  output tic_pkg::result_t                result
);

  typedef struct packed {
    logic [tic_pkg::DATA_W-1:0] cnt;
    logic                       hit;
  } tmr_t;

  logic [tic_pkg::DATA_W-1:0] t1_cnt_r, t1_cnt_nxt, t1_rld_r, t1_rld_nxt, t1_ctl_r, t1_ctl_nxt;
  logic [tic_pkg::DATA_W-1:0] t2_cnt_r, t2_cnt_nxt, t2_rld_r, t2_rld_nxt, t2_ctl_r, t2_ctl_nxt;
  logic [tic_pkg::DATA_W-1:0] wdog_r, wdog_nxt, ps_cnt_r, ps_cnt_nxt, ps_rld_r, ps_rld_nxt;
  logic [tic_pkg::DATA_W-1:0] tick_r, tick_nxt, mask_r, mask_nxt;
  logic [tic_pkg::DATA_W-1:0] pend_r, pend_nxt, force_r, force_nxt;
  logic                       fired_r, fired_nxt;
  logic [tic_pkg::DATA_W-1:0] ack_bit;
  logic [tic_pkg::DATA_W-1:0] rd_val;
  tmr_t                       t1_step, t2_step;

  function automatic tmr_t tmr_tick(input logic [tic_pkg::DATA_W-1:0] cnt,
                                    input logic [tic_pkg::DATA_W-1:0] rld,
                                    input logic [tic_pkg::DATA_W-1:0] ctl);
    tmr_t s;
    s.cnt = cnt;
    s.hit = 1'b0;
    if (ctl[tic_pkg::CTL_EN_BIT]) begin
      if (cnt == '0) begin
        s.hit = 1'b1;
        if (ctl[tic_pkg::CTL_RLD_BIT]) s.cnt = rld;
      end else begin
        s.cnt = cnt - 1'b1;
      end
    end
    return s;
  endfunction

  assign t1_step = tmr_tick(t1_cnt_r, t1_rld_r, t1_ctl_r);
  assign t2_step = tmr_tick(t2_cnt_r, t2_rld_r, t2_ctl_r);
  assign ack_bit = tic_pkg::DATA_W'(1) << item.lvl;

  always_comb begin
    t1_cnt_nxt = t1_cnt_r;  t1_rld_nxt = t1_rld_r;  t1_ctl_nxt = t1_ctl_r;
    t2_cnt_nxt = t2_cnt_r;  t2_rld_nxt = t2_rld_r;  t2_ctl_nxt = t2_ctl_r;
    wdog_nxt   = wdog_r;    ps_cnt_nxt = ps_cnt_r;  ps_rld_nxt = ps_rld_r;
    tick_nxt   = tick_r;    mask_nxt   = mask_r;
    pend_nxt   = pend_r;    force_nxt  = force_r;   fired_nxt  = fired_r;
    if (fire) begin
      unique case (item.op)
        tic_pkg::OP_TICK: begin
          if (ps_cnt_r != '0) begin
            ps_cnt_nxt = ps_cnt_r - 1'b1;
          end else begin
            // prescaler underflow: reload and tick everything behind it
            ps_cnt_nxt = ps_rld_r;
            tick_nxt   = tick_r + 1'b1;
            t1_cnt_nxt = t1_step.cnt;
            t2_cnt_nxt = t2_step.cnt;
            pend_nxt   = pend_r | (t1_step.hit ? tic_pkg::IRQ_T1 : '0)
                                | (t2_step.hit ? tic_pkg::IRQ_T2 : '0);
            if (wdog_r > tic_pkg::DATA_W'(1)) begin
              wdog_nxt = wdog_r - 1'b1;
            end else if (wdog_r == tic_pkg::DATA_W'(1)) begin
              fired_nxt = 1'b1;
            end
          end
        end
        tic_pkg::OP_READ: begin
        end
        tic_pkg::OP_WRITE: begin
          unique case (item.word)
            tic_pkg::W_T1_CNT: t1_cnt_nxt = item.wdata;
            tic_pkg::W_T1_RLD: t1_rld_nxt = item.wdata;
            tic_pkg::W_T1_CTL: begin
              t1_ctl_nxt = item.wdata;
              if (item.wdata[tic_pkg::CTL_LOAD_BIT]) t1_cnt_nxt = t1_rld_r;
            end
            tic_pkg::W_WDOG:   wdog_nxt   = item.wdata;
            tic_pkg::W_T2_CNT: t2_cnt_nxt = item.wdata;
            tic_pkg::W_T2_RLD: t2_rld_nxt = item.wdata;
            tic_pkg::W_T2_CTL: begin
              t2_ctl_nxt = item.wdata;
              if (item.wdata[tic_pkg::CTL_LOAD_BIT]) t2_cnt_nxt = t2_rld_r;
            end
            tic_pkg::W_PS_RLD: ps_rld_nxt = item.wdata;
            tic_pkg::W_MASK:   mask_nxt   = item.wdata;
            tic_pkg::W_PEND:   pend_nxt   = item.wdata;
            tic_pkg::W_FORCE:  force_nxt  = item.wdata;
            tic_pkg::W_CLEAR: begin
              pend_nxt  = pend_r & ~item.wdata;
              force_nxt = force_r & ~item.wdata;
            end
            // prescaler and tick counter are read-only; other words live in the store
            default: begin
            end
          endcase
        end
        tic_pkg::OP_ACK: begin
          pend_nxt  = pend_r & ~ack_bit;
          force_nxt = force_r & ~ack_bit;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (item.word)
      tic_pkg::W_T1_CNT: rd_val = t1_cnt_r;
      tic_pkg::W_T1_RLD: rd_val = t1_rld_r;
      tic_pkg::W_T1_CTL: rd_val = t1_ctl_r;
      tic_pkg::W_WDOG:   rd_val = wdog_r;
      tic_pkg::W_T2_CNT: rd_val = t2_cnt_r;
      tic_pkg::W_T2_RLD: rd_val = t2_rld_r;
      tic_pkg::W_T2_CTL: rd_val = t2_ctl_r;
      tic_pkg::W_PS_CNT: rd_val = ps_cnt_r;
      tic_pkg::W_PS_RLD: rd_val = ps_rld_r;
      tic_pkg::W_TICK:   rd_val = tick_r;
      tic_pkg::W_MASK:   rd_val = mask_r;
      tic_pkg::W_PEND:   rd_val = pend_r;
      tic_pkg::W_FORCE:  rd_val = force_r;
      tic_pkg::W_CLEAR:  rd_val = '0;
      default:           rd_val = store_data;
    endcase
  end

  assign result.read_data = (item.op == tic_pkg::OP_READ) ? rd_val : '0;
  assign result.int_level = tic_pkg::irq_prio((pend_nxt | force_nxt) & mask_nxt);
  assign result.fired     = fired_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_cnt_r <= '0;  t1_rld_r <= '0;  t1_ctl_r <= '0;
      t2_cnt_r <= '0;  t2_rld_r <= '0;  t2_ctl_r <= '0;
      wdog_r   <= '0;  ps_cnt_r <= '0;  ps_rld_r <= '0;
      tick_r   <= '0;  mask_r   <= '0;
      pend_r   <= '0;  force_r  <= '0;  fired_r  <= 1'b0;
    end else begin
      t1_cnt_r <= t1_cnt_nxt;  t1_rld_r <= t1_rld_nxt;  t1_ctl_r <= t1_ctl_nxt;
      t2_cnt_r <= t2_cnt_nxt;  t2_rld_r <= t2_rld_nxt;  t2_ctl_r <= t2_ctl_nxt;
      wdog_r   <= wdog_nxt;    ps_cnt_r <= ps_cnt_nxt;  ps_rld_r <= ps_rld_nxt;
      tick_r   <= tick_nxt;    mask_r   <= mask_nxt;
      pend_r   <= pend_nxt;    force_r  <= force_nxt;   fired_r  <= fired_nxt;
    end
  end

  `TIC_ASSERT_NEXT(a_fired_sticky, fired_r, fired_r, "watchdog flag dropped")
  `TIC_ASSERT_NEXT(a_idle_pend_hold, !fire, $stable(pend_r) && $stable(force_r),
                   "interrupt state moved without an item")
  `TIC_ASSERT_NEXT(a_ps_count_down,
                   fire && item.op == tic_pkg::OP_TICK && ps_cnt_r != '0,
                   $stable(tick_r) && ps_cnt_r == $past(ps_cnt_r) - 1'b1,
                   "prescaler tick without underflow misbehaved")

endmodule

`default_nettype wire

@@ src/timer_irq_controller.sv @@
// Top level of the timer and interrupt controller: input stage, output register.
// Depends on tic_pkg, tic_store and tic_regs.
//
//   channel  direction  tdata fields (low bit up)                    tuser
//   in_      to block   reg_word[5:0] write_data[37:6] ack_level[41:38] opcode[1:0]
//   out_     from block read_data[31:0] int_level[35:32] wdog_flag[36]  -
//
// One item per clock sustained while the output is not stalled; each result passes
// through the input stage, then the output register, from which it is offered and
// can transfer.
// The plain word store is read at the input transfer, so its registered read
// data lines up with the item in the input stage.
// rst_n is synchronous and clears every counter, named register and valid bit, but not the stage data or stored words.
// A stalled output holds both stages; in_tready drops only when both are full
// and out_tready is low.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_irq_controller_assert.svh"

module timer_irq_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // reg_word[5:0], write_data[37:6], ack_level[41:38]
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // read_data[31:0], int_level[35:32], wdog_flag[36]
);

  logic                       s1_valid_r;
  tic_pkg::item_t             s1_item_r;
  logic                       out_valid_r;
  tic_pkg::result_t           out_res_r;
  tic_pkg::item_t             in_item;
  tic_pkg::result_t           res;
  logic                       in_fire;
  logic                       s1_adv;
  logic [tic_pkg::DATA_W-1:0] store_data;

  assign in_item.op    = in_tuser;
  assign in_item.word  = in_tdata[5:0];
  assign in_item.wdata = in_tdata[37:6];
  assign in_item.lvl   = in_tdata[41:38];

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  tic_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_en  (in_fire),
    .wr_en   (in_item.op == tic_pkg::OP_WRITE),
    .word    (in_item.word),
    .wdata   (in_item.wdata),
    .rd_data (store_data)
  );

  tic_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_adv),
    .item       (s1_item_r),
    .store_data (store_data),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (in_fire) s1_item_r <= in_item;
    if (s1_adv)  out_res_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // hold the stage until its result moves on, refill on transfer
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.fired, out_res_r.int_level, out_res_r.read_data};

  `TIC_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_item_r),
                   "input stage lost or changed a held item")
  `TIC_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_r, "advanced item produced no result")
  `TIC_ASSERT_NOW(a_no_overrun, in_fire, !s1_valid_r || s1_adv,
                  "input transfer into a full stage")

endmodule

`default_nettype wire
